// File: hw/rtl/segx_pkg.sv
package segx_pkg;

    // coordinate width, signed Q16.16
    localparam int CW = 32;
    // endpoint difference
    localparam int DW = CW + 1;
    // product of two differences
    localparam int PW = 2 * DW;
    // determinant and numerators
    localparam int NW = PW + 1;
    // divider partial remainder, holds 2*rem + tn < 3*den
    localparam int RW = NW + 1;

    localparam int IN_W  = ((8 * CW + 7) / 8) * 8;
    localparam int OUT_W = ((2 * CW + 7) / 8) * 8;

    // payload of one divider stage
    typedef struct packed {
        logic          hit;
        logic          neg_x;
        logic          neg_y;
        logic [NW-1:0] den;
        logic [NW-1:0] tn;
        logic [CW-1:0] sx;
        logic [CW-1:0] sy;
        logic [RW-1:0] rem_x;
        logic [RW-1:0] rem_y;
        logic [CW-1:0] q_x;
        logic [CW-1:0] q_y;
        logic [CW-1:0] a0_x;
        logic [CW-1:0] a0_y;
    } div_t;

endpackage

// File: hw/rtl/segment_intersection_top.sv
// channel  | dir | tdata (low bit up)                                    | tuser
// ---------+-----+-------------------------------------------------------+------
// s_axis   | in  | a_start_x a_start_y a_end_x a_end_y                   | -
//          |     | b_start_x b_start_y b_end_x b_end_y (32 bits each)    |
// m_axis   | out | cross_x cross_y (32 bits each)                        | hit
//
// one segment pair per cycle while the output is not stalled
// the quotient stages resolve one bit of |s1| per stage
// rst_n clears only the valid bits, payload registers are not reset
// the whole pipeline advances when the output register is empty or taken,
// so a stall holds every stage and loses or repeats no transfer
module segment_intersection_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
    input  logic [segx_pkg::IN_W-1:0]     s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // cross_x, cross_y
    output logic [segx_pkg::OUT_W-1:0]    m_tdata,
    // hit
    output logic                          m_tuser
);

    localparam int CW = segx_pkg::CW;
    localparam int DW = segx_pkg::DW;
    localparam int PW = segx_pkg::PW;
    localparam int NW = segx_pkg::NW;
    localparam int RW = segx_pkg::RW;

    logic en;

    // unpack input fields
    logic signed [CW-1:0] p0x, p0y, p1x, p1y, p2x, p2y, p3x, p3y;
    assign p0x = s_tdata[0*CW +: CW];
    assign p0y = s_tdata[1*CW +: CW];
    assign p1x = s_tdata[2*CW +: CW];
    assign p1y = s_tdata[3*CW +: CW];
    assign p2x = s_tdata[4*CW +: CW];
    assign p2y = s_tdata[5*CW +: CW];
    assign p3x = s_tdata[6*CW +: CW];
    assign p3y = s_tdata[7*CW +: CW];

    // stage 1: differences
    logic                 v1_reg;
    logic signed [DW-1:0] s1x_reg, s1y_reg, s2x_reg, s2y_reg, dx_reg, dy_reg;
    logic [CW-1:0]        a0x1_reg, a0y1_reg;

    // stage 2: products
    logic                 v2_reg;
    logic signed [PW-1:0] pa_reg, pb_reg, pc_reg, pd_reg, pe_reg, pf_reg;
    logic signed [DW-1:0] s1x2_reg, s1y2_reg;
    logic [CW-1:0]        a0x2_reg, a0y2_reg;

    // stage 3: determinant and numerators
    logic                 v3_reg;
    logic signed [NW-1:0] den_reg, sn_reg, tn_reg;
    logic signed [DW-1:0] s1x3_reg, s1y3_reg;
    logic [CW-1:0]        a0x3_reg, a0y3_reg;

    // quotient stages
    segx_pkg::div_t div_reg   [0:CW];
    segx_pkg::div_t div0_next;
    segx_pkg::div_t div_next  [1:CW];
    logic           dv_reg    [0:CW];

    logic             out_valid_reg;
    logic [CW-1:0]    cx_reg, cy_reg;
    logic             hit_reg;

    // pipeline moves when the output slot is free or being taken
    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    // sign correction and range test, feeds divider stage 0
    logic                 neg_den;
    logic signed [NW-1:0] dn, sn2, tn2;
    logic signed [DW-1:0] sxa, sya;
    always_comb
    begin
        neg_den = den_reg[NW-1];
        dn      = neg_den ? -den_reg : den_reg;
        sn2     = neg_den ? -sn_reg  : sn_reg;
        tn2     = neg_den ? -tn_reg  : tn_reg;
        sxa     = s1x3_reg[DW-1] ? -s1x3_reg : s1x3_reg;
        sya     = s1y3_reg[DW-1] ? -s1y3_reg : s1y3_reg;
        div0_next.hit   = (den_reg != '0) && !sn2[NW-1] && !tn2[NW-1]
                          && (sn2 <= dn) && (tn2 <= dn);
        div0_next.neg_x = s1x3_reg[DW-1];
        div0_next.neg_y = s1y3_reg[DW-1];
        div0_next.den   = dn;
        div0_next.tn    = tn2;
        div0_next.sx    = sxa[CW-1:0];
        div0_next.sy    = sya[CW-1:0];
        div0_next.rem_x = '0;
        div0_next.rem_y = '0;
        div0_next.q_x   = '0;
        div0_next.q_y   = '0;
        div0_next.a0_x  = a0x3_reg;
        div0_next.a0_y  = a0y3_reg;
    end

    // one bit of |s1| per stage: rem = 2*rem + bit*tn, quotient digit 0..2
    logic [RW-1:0] tx, ty, d1, d2;
    logic [1:0]    gx, gy;
    always_comb
    begin
        tx = '0;
        ty = '0;
        d1 = '0;
        d2 = '0;
        gx = '0;
        gy = '0;
        for (int k = 0; k < CW; k++)
        begin
            d1 = {1'b0, div_reg[k].den};
            d2 = {div_reg[k].den, 1'b0};
            tx = {div_reg[k].rem_x[RW-2:0], 1'b0}
                 + (div_reg[k].sx[CW-1] ? {1'b0, div_reg[k].tn} : {RW{1'b0}});
            ty = {div_reg[k].rem_y[RW-2:0], 1'b0}
                 + (div_reg[k].sy[CW-1] ? {1'b0, div_reg[k].tn} : {RW{1'b0}});
            gx = 2'd0;
            if (tx >= d2)
            begin
                gx = 2'd2;
                tx = tx - d2;
            end
            else if (tx >= d1)
            begin
                gx = 2'd1;
                tx = tx - d1;
            end
            gy = 2'd0;
            if (ty >= d2)
            begin
                gy = 2'd2;
                ty = ty - d2;
            end
            else if (ty >= d1)
            begin
                gy = 2'd1;
                ty = ty - d1;
            end
            div_next[k+1]       = div_reg[k];
            div_next[k+1].sx    = {div_reg[k].sx[CW-2:0], 1'b0};
            div_next[k+1].sy    = {div_reg[k].sy[CW-2:0], 1'b0};
            div_next[k+1].rem_x = tx;
            div_next[k+1].rem_y = ty;
            div_next[k+1].q_x   = {div_reg[k].q_x[CW-2:0], 1'b0} + {{(CW-2){1'b0}}, gx};
            div_next[k+1].q_y   = {div_reg[k].q_y[CW-2:0], 1'b0} + {{(CW-2){1'b0}}, gy};
        end
    end

    // final point: a_start + signed quotient, zero without a hit
    logic [CW-1:0] qsx, qsy, cx_next, cy_next;
    always_comb
    begin
        qsx     = div_reg[CW].neg_x ? (~div_reg[CW].q_x + 1'b1) : div_reg[CW].q_x;
        qsy     = div_reg[CW].neg_y ? (~div_reg[CW].q_y + 1'b1) : div_reg[CW].q_y;
        cx_next = div_reg[CW].hit ? (div_reg[CW].a0_x + qsx) : '0;
        cy_next = div_reg[CW].hit ? (div_reg[CW].a0_y + qsy) : '0;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k <= CW; k++)
            begin
                dv_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            v1_reg        <= s_tvalid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            dv_reg[0]     <= v3_reg;
            for (int k = 0; k < CW; k++)
            begin
                dv_reg[k+1] <= dv_reg[k];
            end
            out_valid_reg <= dv_reg[CW];
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1x_reg  <= {p1x[CW-1], p1x} - {p0x[CW-1], p0x};
            s1y_reg  <= {p1y[CW-1], p1y} - {p0y[CW-1], p0y};
            s2x_reg  <= {p3x[CW-1], p3x} - {p2x[CW-1], p2x};
            s2y_reg  <= {p3y[CW-1], p3y} - {p2y[CW-1], p2y};
            dx_reg   <= {p0x[CW-1], p0x} - {p2x[CW-1], p2x};
            dy_reg   <= {p0y[CW-1], p0y} - {p2y[CW-1], p2y};
            a0x1_reg <= p0x;
            a0y1_reg <= p0y;

            pa_reg   <= s1x_reg * s2y_reg;
            pb_reg   <= s2x_reg * s1y_reg;
            pc_reg   <= s1x_reg * dy_reg;
            pd_reg   <= s1y_reg * dx_reg;
            pe_reg   <= s2x_reg * dy_reg;
            pf_reg   <= s2y_reg * dx_reg;
            s1x2_reg <= s1x_reg;
            s1y2_reg <= s1y_reg;
            a0x2_reg <= a0x1_reg;
            a0y2_reg <= a0y1_reg;

            den_reg  <= {pa_reg[PW-1], pa_reg} - {pb_reg[PW-1], pb_reg};
            sn_reg   <= {pc_reg[PW-1], pc_reg} - {pd_reg[PW-1], pd_reg};
            tn_reg   <= {pe_reg[PW-1], pe_reg} - {pf_reg[PW-1], pf_reg};
            s1x3_reg <= s1x2_reg;
            s1y3_reg <= s1y2_reg;
            a0x3_reg <= a0x2_reg;
            a0y3_reg <= a0y2_reg;

            div_reg[0] <= div0_next;
            for (int k = 1; k <= CW; k++)
            begin
                div_reg[k] <= div_next[k];
            end

            cx_reg  <= cx_next;
            cy_reg  <= cy_next;
            hit_reg <= div_reg[CW].hit;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = hit_reg;
    assign m_tdata  = {cy_reg, cx_reg};

endmodule
